/* src/conv2d_pkg.sv */
package conv2d_pkg;

    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_KERNEL_DEF     = 5;
    localparam int MAX_CHANNELS_DEF   = 4;
    localparam int COEF_FRAC_BITS_DEF = 14;

    localparam int MAX_HEIGHT = 4095;
    localparam int ROW_W      = 12;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int CIDX_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_PAD    = 2'd1,
        CMD_COEF   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

endpackage

/* src/convolution_2d_clamped_edges_core.sv */
// 2D convolution over an interleaved-channel raster stream with replicated borders.
// Each input beat is accepted in IDLE; a sample or padding beat then checks in CHECK
// whether the next owed result is ready, and if so runs a multiply-accumulate over
// kernel_rows*kernel_cols taps in RUN, one line-store read per cycle, then passes
// through DRAIN, FIN and HOLD; a beat that produces no result returns to IDLE.
// Coefficient beats do not leave IDLE. The line store is a single
// synchronous memory of (MAX_KERNEL+1) rows of MAX_WIDTH*MAX_CHANNELS samples;
// its read port sets the pace. The result sits in an output register, so the next
// beat is taken while it waits; a beat whose result finds it still full holds
// until the earlier result is accepted. Writes to indexes 0-4 restart the frame.
module convolution_2d_clamped_edges_core
    import conv2d_pkg::*;
#(
    parameter int MAX_WIDTH      = conv2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL     = conv2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_CHANNELS   = conv2d_pkg::MAX_CHANNELS_DEF,
    parameter int COEF_FRAC_BITS = conv2d_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // sample_value [15:0], coef_index [20:16], coef_value [36:21], zero [39:37]
    input  logic [39:0]                             s_tdata,
    // command [1:0]
    input  logic [1:0]                              s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // result_value [15:0]
    output logic [15:0]                             m_tdata,
    // saturated [0]
    output logic [0:0]                              m_tuser,
    output logic                                    m_tlast,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [conv2d_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [conv2d_pkg::CFG_DATA_W-1:0]       cfg_data
);
    localparam int RING   = MAX_KERNEL + 1;
    localparam int ROWLEN = MAX_WIDTH * MAX_CHANNELS;
    localparam int DEPTH  = RING * ROWLEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int COLW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CCW    = $clog2(MAX_CHANNELS + 1);
    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int NTAP   = MAX_KERNEL * MAX_KERNEL;
    localparam int TW     = (NTAP > 1) ? $clog2(NTAP) : 1;
    localparam int RGW    = $clog2(RING);
    localparam int ACCW   = SAMPLE_W + COEF_W + $clog2(NTAP + 1) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_RUN   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FIN   = 6'b010000,
        S_HOLD  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  kc_cfg_reg, kr_cfg_reg, ch_cfg_reg;
    logic [10:0] fw_cfg_reg;
    logic [11:0] fh_cfg_reg;

    logic [KW-1:0]    kc, kr, hw, hh;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [CCW-1:0]   ch_eff;

    logic [COLW-1:0]  in_col_reg, out_col_reg;
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    logic [CHW-1:0]   in_ch_reg, out_ch_reg;
    logic [RGW-1:0]   in_ring_reg, out_ring_reg;
    logic             tail_reg;

    logic signed [COEF_W-1:0]   coef_reg [NTAP];
    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    logic [KW-1:0]  ti_reg, tj_reg;
    logic [TW-1:0]  tap_reg;
    logic           v1_reg, v2_reg;
    logic signed [SAMPLE_W-1:0]        rd_reg;
    logic signed [COEF_W-1:0]          cq_reg;
    logic signed [SAMPLE_W+COEF_W-1:0] prod_reg;
    logic signed [ACCW-1:0]            acc_reg;

    logic                 m_valid_reg;
    logic [15:0]          m_data_reg;
    logic                 m_sat_reg, m_last_reg;

    logic                 in_acc, cfg_acc, cfg_hit;
    cmd_t                 cmd;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic                 ready_res;
    logic [ROW_W-1:0]     nr;
    logic [COLW-1:0]      nc;
    logic                 last_tap;
    logic signed [ACCW:0] rnd;
    logic signed [ACCW:0] qv;
    logic                 sat_hi, sat_lo;
    logic [15:0]          q16;
    logic                 is_last;

    // effective (clamped) configuration
    always_comb
    begin
        int v;
        v = (kc_cfg_reg == 3'd0) ? 1 : ((int'(kc_cfg_reg) > MAX_KERNEL) ? MAX_KERNEL
                                                                   : int'(kc_cfg_reg));
        kc = KW'(v);
        v = (kr_cfg_reg == 3'd0) ? 1 : ((int'(kr_cfg_reg) > MAX_KERNEL) ? MAX_KERNEL
                                                                   : int'(kr_cfg_reg));
        kr = KW'(v);
        v = (fw_cfg_reg == 11'd0) ? 1 : ((int'(fw_cfg_reg) > MAX_WIDTH) ? MAX_WIDTH
                                                                    : int'(fw_cfg_reg));
        w_eff = WW'(v);
        v = (fh_cfg_reg == 12'd0) ? 1 : ((int'(fh_cfg_reg) > MAX_HEIGHT) ? MAX_HEIGHT
                                                                     : int'(fh_cfg_reg));
        h_eff = ROW_W'(v);
        v = (ch_cfg_reg == 3'd0) ? 1 : ((int'(ch_cfg_reg) > MAX_CHANNELS) ? MAX_CHANNELS
                                                                      : int'(ch_cfg_reg));
        ch_eff = CCW'(v);
        hw = kc >> 1;
        hh = kr >> 1;
    end

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_acc  = cfg_valid && cfg_ready;
    assign cfg_hit  = cfg_acc && (cfg_index <= REG_CHANNEL_COUNT);

    assign wr_addr = AW'(int'(in_ring_reg) * ROWLEN + int'(in_col_reg) * MAX_CHANNELS
                         + int'(in_ch_reg));

    // emission check: strict raster order compare of received vs needed position
    always_comb
    begin
        int r, c;
        r = int'(out_row_reg) + int'(hh);
        if (r > int'(h_eff) - 1)
            r = int'(h_eff) - 1;
        c = int'(out_col_reg) + int'(hw);
        if (c > int'(w_eff) - 1)
            c = int'(w_eff) - 1;
        nr = ROW_W'(r);
        nc = COLW'(c);
        ready_res = tail_reg || (in_row_reg > nr) ||
                    ((in_row_reg == nr) && ((in_col_reg > nc) ||
                    ((in_col_reg == nc) && (in_ch_reg > out_ch_reg))));
    end

    // tap address with clamped coordinates
    always_comb
    begin
        int y, x, d, rg;
        y = int'(out_row_reg) + int'(ti_reg) - int'(hh);
        if (y < 0)
            y = 0;
        if (y > int'(h_eff) - 1)
            y = int'(h_eff) - 1;
        x = int'(out_col_reg) + int'(tj_reg) - int'(hw);
        if (x < 0)
            x = 0;
        if (x > int'(w_eff) - 1)
            x = int'(w_eff) - 1;
        d  = y - int'(out_row_reg);
        rg = int'(out_ring_reg) + d;
        if (rg < 0)
            rg = rg + RING;
        else if (rg >= RING)
            rg = rg - RING;
        rd_addr  = AW'(rg * ROWLEN + x * MAX_CHANNELS + int'(out_ch_reg));
        last_tap = (int'(ti_reg) == int'(kr) - 1) && (int'(tj_reg) == int'(kc) - 1);
    end

    // round half up, saturate
    always_comb
    begin
        rnd    = (ACCW+1)'(acc_reg) + ((ACCW+1)'(1) <<< (COEF_FRAC_BITS - 1));
        qv     = rnd >>> COEF_FRAC_BITS;
        sat_hi = (qv > (ACCW+1)'(32767));
        sat_lo = (qv < -(ACCW+1)'(32768));
        q16    = sat_hi ? 16'h7FFF : (sat_lo ? 16'h8000 : qv[15:0]);
        is_last = (out_row_reg == h_eff - ROW_W'(1)) &&
                  (int'(out_col_reg) == int'(w_eff) - 1) &&
                  (int'(out_ch_reg) == int'(ch_eff) - 1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (cmd == CMD_SAMPLE || cmd == CMD_PAD))
                    state_next = S_CHECK;
            end
            S_CHECK:
                state_next = ready_res ? S_RUN : S_IDLE;
            S_RUN:
            begin
                if (last_tap)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_FIN;
            end
            S_FIN:
                state_next = S_HOLD;
            S_HOLD:
            begin
                if (!m_valid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // line store
    always_ff @(posedge clk)
    begin
        if (in_acc && cmd == CMD_SAMPLE)
            mem[wr_addr] <= s_tdata[SAMPLE_W-1:0];
        rd_reg <= mem[rd_addr];
    end

    // datapath: read, multiply, accumulate
    always_ff @(posedge clk)
    begin
        cq_reg   <= coef_reg[tap_reg];
        prod_reg <= rd_reg * cq_reg;
        if (state_reg == S_CHECK)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + ACCW'(prod_reg);
        if (state_reg == S_FIN)
        begin
            m_data_reg <= q16;
            m_sat_reg  <= sat_hi || sat_lo;
            m_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ti_reg  <= '0;
            tj_reg  <= '0;
            tap_reg <= '0;
        end
        else
        begin
            v1_reg <= (state_reg == S_RUN);
            v2_reg <= v1_reg;
            if (state_reg == S_CHECK)
            begin
                ti_reg  <= '0;
                tj_reg  <= '0;
                tap_reg <= '0;
            end
            else if (state_reg == S_RUN)
            begin
                tap_reg <= tap_reg + TW'(1);
                if (int'(tj_reg) == int'(kc) - 1)
                begin
                    tj_reg <= '0;
                    ti_reg <= ti_reg + KW'(1);
                end
                else
                    tj_reg <= tj_reg + KW'(1);
            end
        end
    end

    // coefficients
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NTAP; k++)
                coef_reg[k] <= '0;
        end
        else if (in_acc && cmd == CMD_COEF &&
                 int'(s_tdata[20:16]) < int'(kc) * int'(kr))
            coef_reg[TW'(s_tdata[20:16])] <= s_tdata[36:21];
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_cfg_reg <= 3'd3;
            kr_cfg_reg <= 3'd3;
            fw_cfg_reg <= 11'd1024;
            fh_cfg_reg <= 12'd1024;
            ch_cfg_reg <= 3'd1;
        end
        else if (cfg_acc)
        begin
            unique case (cfg_index)
                REG_KERNEL_COLS:   kc_cfg_reg <= cfg_data[2:0];
                REG_KERNEL_ROWS:   kr_cfg_reg <= cfg_data[2:0];
                REG_FRAME_WIDTH:   fw_cfg_reg <= cfg_data[10:0];
                REG_FRAME_HEIGHT:  fh_cfg_reg <= cfg_data[11:0];
                REG_CHANNEL_COUNT: ch_cfg_reg <= cfg_data[2:0];
                default:           ;
            endcase
        end
    end

    // frame positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ch_reg    <= '0;
            in_ring_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ch_reg   <= '0;
            out_ring_reg <= '0;
            tail_reg     <= 1'b0;
        end
        else if (cfg_hit)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ch_reg    <= '0;
            in_ring_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ch_reg   <= '0;
            out_ring_reg <= '0;
            tail_reg     <= 1'b0;
        end
        else if (in_acc && cmd == CMD_SAMPLE)
        begin
            // a new frame drops what is still owed from the old one
            if (tail_reg)
            begin
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_ch_reg   <= '0;
                out_ring_reg <= '0;
            end
            if (int'(in_ch_reg) + 1 >= int'(ch_eff))
            begin
                in_ch_reg <= '0;
                if (int'(in_col_reg) + 1 >= int'(w_eff))
                begin
                    in_col_reg <= '0;
                    if (int'(in_row_reg) + 1 >= int'(h_eff))
                    begin
                        in_row_reg  <= '0;
                        in_ring_reg <= '0;
                        tail_reg    <= 1'b1;
                    end
                    else
                    begin
                        in_row_reg  <= in_row_reg + ROW_W'(1);
                        in_ring_reg <= (int'(in_ring_reg) == RING - 1) ? '0
                                       : in_ring_reg + RGW'(1);
                        tail_reg    <= 1'b0;
                    end
                end
                else
                begin
                    in_col_reg <= in_col_reg + COLW'(1);
                    tail_reg   <= 1'b0;
                end
            end
            else
            begin
                in_ch_reg <= in_ch_reg + CHW'(1);
                tail_reg  <= 1'b0;
            end
        end
        else if (state_reg == S_FIN)
        begin
            if (int'(out_ch_reg) + 1 >= int'(ch_eff))
            begin
                out_ch_reg <= '0;
                if (int'(out_col_reg) + 1 >= int'(w_eff))
                begin
                    out_col_reg <= '0;
                    if (int'(out_row_reg) + 1 >= int'(h_eff))
                    begin
                        out_row_reg  <= '0;
                        out_ring_reg <= '0;
                        tail_reg     <= 1'b0;
                    end
                    else
                    begin
                        out_row_reg  <= out_row_reg + ROW_W'(1);
                        out_ring_reg <= (int'(out_ring_reg) == RING - 1) ? '0
                                        : out_ring_reg + RGW'(1);
                    end
                end
                else
                    out_col_reg <= out_col_reg + COLW'(1);
            end
            else
                out_ch_reg <= out_ch_reg + CHW'(1);
        end
    end

    // output register: load on leaving HOLD
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (state_reg == S_HOLD && (!m_valid_reg || m_tready))
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    // output payload registers move with the valid
    logic [15:0] o_data_reg;
    logic        o_sat_reg, o_last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_HOLD && (!m_valid_reg || m_tready))
        begin
            o_data_reg <= m_data_reg;
            o_sat_reg  <= m_sat_reg;
            o_last_reg <= m_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_sat_reg;
    assign m_tlast  = o_last_reg;

endmodule

/* src/conv2d_checker.sv */
module conv2d_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [15:0] m_tdata
);
    import conv2d_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // a result does not appear straight after an accepted input beat
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after an input beat");

    // coefficient and unused beats leave the input ready
    a_coef_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_COEF || s_tuser == CMD_NONE) |=> s_tready)
        else $error("coefficient beat stalled the input");

endmodule

bind convolution_2d_clamped_edges_core conv2d_checker u_conv2d_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
